// ===== hw/rtl/rra_pkg.sv =====
// rra_pkg: shared types and constants for the rectangle region allocator.
// No dependencies.
package rra_pkg;

  localparam int unsigned CoordW = 16;

  typedef logic [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } area_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOROOM = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic [1:0] REG_XMIN = 2'd0;
  localparam logic [1:0] REG_YMIN = 2'd1;
  localparam logic [1:0] REG_XMAX = 2'd2;
  localparam logic [1:0] REG_YMAX = 2'd3;

  typedef struct packed {
    logic   req_type;
    coord_t req_width;
    coord_t req_height;
  } req_t;

  typedef struct packed {
    status_t status;
    coord_t  alloc_x;
    coord_t  alloc_y;
  } rsp_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,  // latch request, reset scan
    OP_CLEAR  = 3'd2,  // table back to the region
    OP_SCAN   = 3'd3,  // read one entry a cycle and classify it
    OP_REMOVE = 3'd4,  // close up the entries behind the exact fit
    OP_SHRINK = 3'd5,  // trim the one-dimension fit
    OP_SPLIT  = 3'd6,  // move every entry one slot down, one a cycle
    OP_FINAL  = 3'd7   // write strip at the head
  } dp_op_t;

  typedef struct packed {
    logic    scan_done;  // every entry classified, no exact fit
    logic    exact_hit;  // exact fit found
    logic    has_near;
    logic    has_loose;
    logic    full;
    logic    move_done;  // close-up or shift pass finished
  } dp_status_t;

endpackage

// ===== hw/rtl/rra_if.sv =====
// rra_if: valid/ready channel carrying one payload type.
// Depends on nothing; payload type set by parameter.
interface rra_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rra_datapath.sv =====
// rra_datapath: free table memory, scan cursor, fit tracking and result fields.
// Depends on rra_pkg.
module rra_datapath #(
  parameter int unsigned MaxFree = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  rra_pkg::dp_op_t     op,
  input  rra_pkg::req_t       req,
  input  rra_pkg::area_t      region,
  output rra_pkg::dp_status_t stat,
  output rra_pkg::coord_t     res_x,
  output rra_pkg::coord_t     res_y
);
  import rra_pkg::*;

  localparam int unsigned IdxW = (MaxFree > 1) ? $clog2(MaxFree) : 1;
  localparam int unsigned CntW = $clog2(MaxFree + 1);

  area_t           mem [MaxFree];
  area_t           rdata;
  logic            rvalid;     // rdata holds entry ridx
  logic [CntW-1:0] ridx;
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx, idx_next;  // read cursor
  logic [CntW-1:0] sel_idx;
  logic [CntW-1:0] near_idx, loose_idx;
  logic            exact, has_near, has_loose;
  logic            near_eqw, sel_eqw;
  area_t           near_ent, loose_ent, sel;
  coord_t          w, h;

  logic            issue, scan_eval, exact_now, scan_done, move_done;
  logic [CntW-1:0] raddr;
  logic            we;
  logic [CntW-1:0] waddr;
  area_t           wdata;

  // fit check on rdata, 17-bit signed differences
  logic signed [CoordW:0] rw, rh, sw, sh;
  logic fit, eqw, eqh;
  always_comb begin
    sw  = $signed({1'b0, w});
    sh  = $signed({1'b0, h});
    rw  = $signed({1'b0, rdata.x1}) - $signed({1'b0, rdata.x0});
    rh  = $signed({1'b0, rdata.y1}) - $signed({1'b0, rdata.y0});
    eqw = (rw == sw);
    eqh = (rh == sh);
    fit = (sw <= rw) && (sh <= rh);
  end

  // read side: at most one entry read a cycle
  always_comb begin
    issue = 1'b0;
    raddr = idx;
    case (op)
      OP_SCAN:   issue = !exact && (idx < count);
      OP_REMOVE: issue = (idx < count);
      OP_SPLIT: begin
        // descending pass: read idx-1, later write it to idx
        issue = (idx != '0);
        raddr = idx - CntW'(1);
      end
      default: ;
    endcase
  end

  assign scan_eval = (op == OP_SCAN) && rvalid && !exact && fit;
  assign exact_now = scan_eval && eqw && eqh;
  assign scan_done = (op == OP_SCAN) && !exact && !rvalid && (idx >= count);
  assign move_done = ((op == OP_REMOVE) || (op == OP_SPLIT)) && !rvalid && !issue;

  always_comb begin
    idx_next = idx;
    if (issue) idx_next = (op == OP_SPLIT) ? idx - CntW'(1) : idx + CntW'(1);
    case (op)
      OP_LOAD: idx_next = '0;
      OP_SCAN: begin
        if (exact_now) idx_next = ridx + CntW'(1);
        if (scan_done) idx_next = count;
      end
      default: ;
    endcase
  end

  // write side: one entry a cycle
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    case (op)
      OP_CLEAR: begin
        we    = 1'b1;
        wdata = region;
      end
      OP_REMOVE: begin
        we    = rvalid;
        waddr = ridx - CntW'(1);
      end
      OP_SHRINK: begin
        we    = 1'b1;
        waddr = sel_idx;
        wdata = sel;
        if (sel_eqw) wdata.y0 = sel.y0 + h;
        else         wdata.x0 = sel.x0 + w;
      end
      OP_SPLIT: begin
        we    = rvalid;
        waddr = ridx + CntW'(1);
        // the split entry keeps only the part below the allocation
        if (ridx == sel_idx) begin
          wdata    = sel;
          wdata.y0 = sel.y0 + h;
        end
      end
      OP_FINAL: begin
        we    = 1'b1;
        wdata = '{x0: sel.x0 + w, y0: sel.y0, x1: sel.x1, y1: sel.y0 + h};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr[IdxW-1:0]] <= wdata;
    if (issue) rdata <= mem[raddr[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid    <= 1'b0;
      ridx      <= '0;
      count     <= CntW'(1);
      idx       <= '0;
      exact     <= 1'b0;
      has_near  <= 1'b0;
      has_loose <= 1'b0;
      near_idx  <= '0;
      loose_idx <= '0;
      sel_idx   <= '0;
      near_eqw  <= 1'b0;
      sel_eqw   <= 1'b0;
    end else begin
      rvalid <= issue;
      idx    <= idx_next;
      if (issue) ridx <= raddr;
      case (op)
        OP_LOAD: begin
          exact     <= 1'b0;
          has_near  <= 1'b0;
          has_loose <= 1'b0;
        end
        OP_CLEAR: count <= CntW'(1);
        OP_SCAN: begin
          if (scan_eval) begin
            if (eqw && eqh) begin
              exact   <= 1'b1;
              sel_idx <= ridx;
            end else if (eqw || eqh) begin
              has_near <= 1'b1;
              near_idx <= ridx;
              near_eqw <= eqw;
            end else begin
              has_loose <= 1'b1;
              loose_idx <= ridx;
            end
          end
          if (scan_done) begin
            sel_idx <= has_near ? near_idx : loose_idx;
            sel_eqw <= near_eqw;
          end
        end
        OP_REMOVE: if (move_done) count <= count - CntW'(1);
        OP_FINAL:  count <= count + CntW'(1);
        default: ;
      endcase
    end
  end

  // request fields and captured entries
  always_ff @(posedge clk) begin
    if (op == OP_LOAD) begin
      w <= req.req_width;
      h <= req.req_height;
    end
    if (exact_now) sel <= rdata;
    else if (scan_done) sel <= has_near ? near_ent : loose_ent;
    if (scan_eval && !(eqw && eqh)) begin
      if (eqw || eqh) near_ent <= rdata;
      else            loose_ent <= rdata;
    end
  end

  assign stat.scan_done = scan_done;
  assign stat.exact_hit = exact;
  assign stat.has_near  = has_near;
  assign stat.has_loose = has_loose;
  assign stat.full      = (count >= CntW'(MaxFree));
  assign stat.move_done = move_done;

  assign res_x = sel.x0;
  assign res_y = sel.y0;

endmodule

// ===== hw/rtl/rra_ctrl.sv =====
// rra_ctrl: request sequencer for the allocator; drives datapath operations.
// Depends on rra_pkg.
module rra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_kind,
  output logic                out_valid,
  input  logic                out_ready,
  output rra_pkg::status_t    out_status,
  output logic                use_coord,
  output rra_pkg::dp_op_t     op,
  input  rra_pkg::dp_status_t stat
);
  import rra_pkg::*;

  typedef enum logic [7:0] {
    S_INIT   = 8'b00000001,
    S_IDLE   = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_REMOVE = 8'b00001000,
    S_SHRINK = 8'b00010000,
    S_SPLIT  = 8'b00100000,
    S_FINAL  = 8'b01000000,
    S_RESP   = 8'b10000000
  } state_t;

  state_t  state, state_next;
  status_t st_reg, st_next;
  logic    uc_reg, uc_next;
  logic    pending, pending_next;

  assign in_ready   = (state == S_IDLE) && !pending;
  assign out_valid  = pending;
  assign out_status = st_reg;
  assign use_coord  = uc_reg;

  always_comb begin
    state_next   = state;
    st_next      = st_reg;
    uc_next      = uc_reg;
    pending_next = pending && !out_ready;
    op           = OP_NONE;
    case (state)
      S_INIT: begin
        // table back to the region, after reset and on a clear
        op         = OP_CLEAR;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op = OP_LOAD;
          if (req_kind == REQ_CLEAR) begin
            st_next = ST_OK; uc_next = 1'b0; state_next = S_INIT;
            pending_next = 1'b1;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        op = OP_SCAN;
        if (stat.exact_hit) state_next = S_REMOVE;
        else if (stat.scan_done) begin
          if (stat.has_near) state_next = S_SHRINK;
          else if (stat.has_loose) begin
            if (stat.full) begin
              st_next = ST_FULL; uc_next = 1'b0; state_next = S_RESP;
            end else state_next = S_SPLIT;
          end else begin
            st_next = ST_NOROOM; uc_next = 1'b0; state_next = S_RESP;
          end
        end
      end
      S_REMOVE: begin
        op = OP_REMOVE;
        if (stat.move_done) begin
          st_next = ST_OK; uc_next = 1'b1; state_next = S_RESP;
        end
      end
      S_SHRINK: begin
        op = OP_SHRINK;
        st_next = ST_OK; uc_next = 1'b1; state_next = S_RESP;
      end
      S_SPLIT: begin
        op = OP_SPLIT;
        if (stat.move_done) state_next = S_FINAL;
      end
      S_FINAL: begin
        op = OP_FINAL;
        st_next = ST_OK; uc_next = 1'b1; state_next = S_RESP;
      end
      S_RESP: begin
        pending_next = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      pending <= 1'b0;
      st_reg  <= ST_OK;
      uc_reg  <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      st_reg  <= st_next;
      uc_reg  <= uc_next;
    end
  end

  a_resp_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) |=> pending) else $error("result not raised");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_full_no_coord: assert property (@(posedge clk) disable iff (rst)
    (pending && st_reg != ST_OK) |-> !uc_reg) else $error("coord on failure");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (pending && !out_ready) |=> (pending && $stable(st_reg) && $stable(uc_reg)))
    else $error("result changed while waiting");

endmodule

// ===== hw/rtl/rectangle_region_allocator.sv =====
// rectangle_region_allocator: top level, region registers and result formatting.
// Depends on rra_pkg, rra_if, rra_ctrl and rra_datapath.
//
// Guillotine allocator over a table of up to MAX_FREE free rectangles held in a
// memory with one read and one write a cycle. One request is in flight at a
// time; the next is taken on the cycle after the result beat. A clear answers
// on the cycle after it is accepted. An allocate scans one entry a cycle. No
// room or a full table is reported when the scan ends; a one-dimension fit
// first trims the entry, an exact fit first closes up the entries behind it
// one a cycle, and a split first moves every entry one slot down before the
// strip lands at the head. Register writes reach the table only at the next
// clear.
module rectangle_region_allocator #(
  parameter int unsigned MAX_FREE = 64
) (
  input  logic        clk,
  input  logic        rst,
  rra_if.sink         req,
  rra_if.source       rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rra_pkg::*;

  area_t      region;
  dp_op_t     op;
  dp_status_t stat;
  coord_t     rx, ry;
  status_t    st;
  logic       uc;

  always_ff @(posedge clk) begin
    if (rst) begin
      region <= '{x0: '0, y0: '0, x1: 16'd1024, y1: 16'd1024};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_XMIN: region.x0 <= cfg_data;
        REG_YMIN: region.y0 <= cfg_data;
        REG_XMAX: region.x1 <= cfg_data;
        REG_YMAX: region.y1 <= cfg_data;
        default: ;
      endcase
    end
  end

  rra_ctrl u_ctrl (
    .clk, .rst,
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .req_kind  (req.data.req_type),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_status(st),
    .use_coord (uc),
    .op, .stat
  );

  rra_datapath #(.MaxFree(MAX_FREE)) u_dp (
    .clk, .rst, .op,
    .req   (req.data),
    .region,
    .stat,
    .res_x (rx),
    .res_y (ry)
  );

  assign rsp.data = '{status: st, alloc_x: uc ? rx : '0, alloc_y: uc ? ry : '0};

endmodule

// ===== sim/tb_rra_if_note.sv =====
// Testbench helper types for the rectangle region allocator.
// Depends on rra_pkg only.
package tb_rra_pkg;
  import rra_pkg::*;

  // Predicts allocator results and checks the response beats against them.
  class alloc_scoreboard;
    coord_t reg_x0, reg_y0, reg_x1, reg_y1;
    area_t  free_list[$];
    int     max_free;
    rsp_t   pending[$];
    int     errors;

    function new(int depth);
      max_free = depth;
      reg_x0 = 16'd0;
      reg_y0 = 16'd0;
      reg_x1 = 16'd1024;
      reg_y1 = 16'd1024;
      errors = 0;
      reload();
    endfunction

    function void reload();
      area_t a;
      a.x0 = reg_x0;
      a.y0 = reg_y0;
      a.x1 = reg_x1;
      a.y1 = reg_y1;
      free_list = '{a};
    endfunction

    function void write_reg(logic [1:0] idx, coord_t v);
      case (idx)
        REG_XMIN: reg_x0 = v;
        REG_YMIN: reg_y0 = v;
        REG_XMAX: reg_x1 = v;
        REG_YMAX: reg_y1 = v;
        default: ;
      endcase
    endfunction

    function int entries();
      return free_list.size();
    endfunction

    // Note one accepted request beat and queue its expected response.
    function void note_request(req_t r);
      rsp_t  p;
      int    near_at, loose_at, rw, rh, w, h;
      area_t e, strip;
      p = '{status: ST_OK, alloc_x: '0, alloc_y: '0};
      near_at = -1;
      loose_at = -1;
      w = r.req_width;
      h = r.req_height;
      if (r.req_type == REQ_CLEAR) begin
        reload();
        pending.push_back(p);
        return;
      end
      foreach (free_list[i]) begin
        e = free_list[i];
        rw = int'(e.x1) - int'(e.x0);
        rh = int'(e.y1) - int'(e.y0);
        if (w == rw && h == rh) begin
          p.alloc_x = e.x0;
          p.alloc_y = e.y0;
          free_list.delete(i);
          pending.push_back(p);
          return;
        end
        if (w <= rw && h <= rh) begin
          if (w == rw || h == rh) near_at = i;
          else loose_at = i;
        end
      end
      if (near_at >= 0) begin
        e = free_list[near_at];
        p.alloc_x = e.x0;
        p.alloc_y = e.y0;
        if (w == int'(e.x1) - int'(e.x0)) e.y0 = e.y0 + coord_t'(h);
        else e.x0 = e.x0 + coord_t'(w);
        free_list[near_at] = e;
      end else if (loose_at >= 0) begin
        if (free_list.size() >= max_free) begin
          p.status = ST_FULL;
        end else begin
          e = free_list[loose_at];
          p.alloc_x = e.x0;
          p.alloc_y = e.y0;
          strip.x0 = e.x0 + coord_t'(w);
          strip.y0 = e.y0;
          strip.x1 = e.x1;
          strip.y1 = e.y0 + coord_t'(h);
          e.y0 = e.y0 + coord_t'(h);
          free_list[loose_at] = e;
          free_list.push_front(strip);
        end
      end else begin
        p.status = ST_NOROOM;
      end
      pending.push_back(p);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("response beat with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.alloc_x !== want.alloc_x) begin
        $error("alloc_x: expected %0d, got %0d", want.alloc_x, got.alloc_x);
        errors++;
      end
      if (got.alloc_y !== want.alloc_y) begin
        $error("alloc_y: expected %0d, got %0d", want.alloc_y, got.alloc_y);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== sim/tb_top.sv =====
// tb_top: randomised check of the rectangle region allocator.
// Depends on rra_pkg, rra_if, rectangle_region_allocator and tb_rra_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rra_pkg::*;
  import tb_rra_pkg::*;

  localparam int unsigned MaxFree = 64;
  localparam int CycleLimit = 3000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          cycles;
  bit          stall_long;
  bit          driving_done;
  alloc_scoreboard board;

  rra_if #(.payload_t(req_t)) req ();
  rra_if #(.payload_t(rsp_t)) rsp ();

  rectangle_region_allocator #(.MAX_FREE(MaxFree)) uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Response side: random stalls, sampled at the rising edge.
  initial begin
    int g;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_long) begin
        rsp.ready <= 1'b0;
        repeat (400) @(negedge clk);
        stall_long = 1'b0;
      end
      g = driving_done ? 0 : gap_len();
      if (g > 0) begin
        rsp.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) board.check_response(rsp.data);
  end

  // valid stays high after the accepting edge until the next negedge decision
  task automatic send(logic kind, coord_t w, coord_t h);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      req.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data <= '{req_type: kind, req_width: w, req_height: h};
    do @(posedge clk); while (!req.ready);
    board.note_request('{req_type: kind, req_width: w, req_height: h});
  endtask

  task automatic idle_req();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  task automatic alloc(coord_t w, coord_t h);
    send(REQ_ALLOC, w, h);
  endtask

  task automatic clear_table();
    send(REQ_CLEAR, coord_t'($urandom), coord_t'($urandom));
  endtask

  // Waits for all results, then a pause, writes all four registers, then clears the table.
  task automatic set_region(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    idle_req();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data <= (i == 0) ? x0 : (i == 1) ? y0 : (i == 2) ? x1 : y1;
      board.write_reg(i[1:0], (i == 0) ? x0 : (i == 1) ? y0 : (i == 2) ? x1 : y1);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    clear_table();
  endtask

  // Random item: mostly sizes up to span, some clears, random sizes and exact fits of the head entry.
  task automatic random_item(int span);
    int r;
    coord_t w, h;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      clear_table();
    end else if (r < 12) begin
      alloc(coord_t'($urandom), coord_t'($urandom));
    end else if (r < 16 && board.entries() > 0) begin
      alloc(board.free_list[0].x1 - board.free_list[0].x0,
            board.free_list[0].y1 - board.free_list[0].y0);
    end else begin
      w = coord_t'($urandom_range(0, span));
      h = coord_t'($urandom_range(0, span));
      alloc(w, h);
    end
  endtask

  initial begin
    board = new(MaxFree);
    cycles = 0;
    stall_long = 1'b0;
    driving_done = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_XMIN;
    cfg_data = '0;
    req.valid = 1'b0;
    req.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset region, exact, one-dimension and loose fits
    alloc(16'd1024, 16'd1024);
    alloc(16'd1, 16'd1);
    clear_table();
    alloc(16'hFFFF, 16'hFFFF);
    alloc(16'd0, 16'd0);
    alloc(16'd1024, 16'd10);
    alloc(16'd100, 16'd1014);
    alloc(16'd30, 16'd40);
    alloc(16'd894, 16'd974);
    alloc(16'd0, 16'd5);
    clear_table();
    // inverted region never fits
    set_region(16'd500, 16'd500, 16'd10, 16'd10);
    alloc(16'd0, 16'd0);
    alloc(16'd1, 16'd1);
    set_region(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    alloc(16'd0, 16'd0);
    alloc(16'd0, 16'd0);
    set_region(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    // growing heights give a loose split every time until the table is full
    for (int i = 0; i < 66; i++) alloc(16'd1, coord_t'(i + 1));
    alloc(16'd1023, 16'd1);
    clear_table();
    alloc(16'hFFFF, 16'h8000);
    alloc(16'h8000, 16'h7FFF);

    for (int phase = 0; phase < 4; phase++) begin
      int span;
      if (phase == 1) set_region(16'd0, 16'd0, 16'd64, 16'd64);
      if (phase == 2) set_region(coord_t'($urandom), coord_t'($urandom),
                                 coord_t'($urandom), coord_t'($urandom));
      if (phase == 3) set_region(16'd100, 16'd200, 16'd356, 16'd328);
      span = (phase == 0) ? 300 : (phase == 1) ? 24 : (phase == 3) ? 64 : 16'hFFFF;
      for (int n = 0; n < 180; n++) begin
        if (phase == 1 && n == 50) stall_long = 1'b1;
        random_item(span);
      end
    end
    idle_req();
    driving_done = 1'b1;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("tb_top failed");
    $finish;
  end
endmodule
